### src/lts_pkg.sv
`timescale 1ns / 1ps

package lts_pkg;

   localparam int POS_W  = 16;
   localparam int LINE_W = 16;
   localparam int KW_MAX = 6;
   localparam int WL_W   = $clog2(KW_MAX + 2);
   localparam int WIDX_W = $clog2(KW_MAX);
   localparam int KW_COUNT = 16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [POS_W-1:0]  POS_MAX  = '1;
   localparam logic [LINE_W-1:0] LINE_MAX = '1;

   localparam logic [5:0] K_LPAREN   = 6'd0;
   localparam logic [5:0] K_RPAREN   = 6'd1;
   localparam logic [5:0] K_LBRACE   = 6'd2;
   localparam logic [5:0] K_RBRACE   = 6'd3;
   localparam logic [5:0] K_COMMA    = 6'd4;
   localparam logic [5:0] K_DOT      = 6'd5;
   localparam logic [5:0] K_MINUS    = 6'd6;
   localparam logic [5:0] K_PLUS     = 6'd7;
   localparam logic [5:0] K_SEMI     = 6'd8;
   localparam logic [5:0] K_ASTERISK = 6'd9;
   localparam logic [5:0] K_LBRACKET = 6'd10;
   localparam logic [5:0] K_RBRACKET = 6'd11;
   localparam logic [5:0] K_BANG     = 6'd12;
   localparam logic [5:0] K_EQUAL    = 6'd14;
   localparam logic [5:0] K_LESS     = 6'd16;
   localparam logic [5:0] K_GREATER  = 6'd18;
   localparam logic [5:0] K_SLASH    = 6'd20;
   localparam logic [5:0] K_IDENT    = 6'd21;
   localparam logic [5:0] K_NUMBER   = 6'd22;
   localparam logic [5:0] K_KEYWORD0 = 6'd23;
   localparam logic [5:0] K_EOF      = 6'd39;
   localparam logic [5:0] K_ERROR    = 6'd40;

   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_UNEXPECTED  = 3'd1;
   localparam logic [2:0] ERR_NO_FRACTION = 3'd2;
   localparam logic [2:0] ERR_TWO_POINTS  = 3'd3;
   localparam logic [2:0] ERR_NO_EXPONENT = 3'd4;

   localparam logic [7:0] CH_LPAREN   = "(";
   localparam logic [7:0] CH_RPAREN   = ")";
   localparam logic [7:0] CH_LBRACE   = "{";
   localparam logic [7:0] CH_RBRACE   = "}";
   localparam logic [7:0] CH_COMMA    = ",";
   localparam logic [7:0] CH_POINT    = ".";
   localparam logic [7:0] CH_MINUS    = "-";
   localparam logic [7:0] CH_PLUS     = "+";
   localparam logic [7:0] CH_SEMI     = ";";
   localparam logic [7:0] CH_ASTERISK = "*";
   localparam logic [7:0] CH_LBRACKET = "[";
   localparam logic [7:0] CH_RBRACKET = "]";
   localparam logic [7:0] CH_BANG     = "!";
   localparam logic [7:0] CH_EQUAL    = "=";
   localparam logic [7:0] CH_LESS     = "<";
   localparam logic [7:0] CH_GREATER  = ">";
   localparam logic [7:0] CH_SLASH    = "/";
   localparam logic [7:0] CH_SPACE    = " ";
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_NEWLINE  = 8'h0A;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_LOWER_E  = "e";
   localparam logic [7:0] CH_UPPER_E  = "E";
   localparam logic [7:0] CH_LOWER_F  = "f";
   localparam logic [7:0] CH_LOWER_I  = "i";
   localparam logic [7:0] CH_LOWER_U  = "u";
   localparam logic [7:0] CH_UNDERSCORE = "_";

   typedef enum logic [3:0] {
      M_IDLE, M_BANG, M_EQ, M_LESS, M_GREATER, M_SLASH, M_COMMENT, M_DOT,
      M_IDENT, M_NUM_BODY, M_NUM_POINT, M_EXP_SIGN, M_EXP_FIRST,
      M_EXP_DIGITS, M_SUF_DIGITS
   } mode_type;

   typedef logic [KW_MAX-1:0][7:0] word_buf_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [15:0] line;
      logic [2:0]  error;
      logic        last;
   } token_type;

   typedef struct packed {
      logic      first_valid;
      logic      second_valid;
      token_type first;
      token_type second;
   } push_type;

   localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_COUNT] = '{
      "and", "class", "else", "false", "for", "fun", "if", "nil",
      "or", "print", "return", "super", "this", "true", "var", "while"
   };
   localparam logic [WL_W-1:0] KW_LEN [KW_COUNT] = '{
      3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
      3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
   };

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"))
             || (c == CH_UNDERSCORE);
   endfunction

   function automatic logic [15:0] sat16(input logic [31:0] v);
      return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic logic [15:0] token_len(input logic [POS_W-1:0] last_pos,
                                              input logic [POS_W-1:0] first_pos);
      logic [POS_W-1:0] diff;
      diff = last_pos - first_pos;
      return (last_pos >= first_pos) ? sat16(32'(diff)) : 16'd0;
   endfunction

   function automatic logic [2:0] first_err(input logic [2:0] current,
                                            input logic [2:0] fresh);
      return (current == ERR_NONE) ? fresh : current;
   endfunction

   function automatic logic [5:0] kw_kind(input word_buf_type wbuf,
                                          input logic [WL_W-1:0] len);
      logic [5:0] kind;
      logic       hit;
      int         idx;
      kind = K_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         hit = (len == KW_LEN[k]);
         for (int i = 0; i < KW_MAX; i++) begin
            if (i < int'(KW_LEN[k])) begin
               idx = 8 * (int'(KW_LEN[k]) - 1 - i);
               if (wbuf[i] != KW_TEXT[k][idx +: 8]) begin
                  hit = 1'b0;
               end
            end
         end
         if (hit) begin
            kind = 6'(int'(K_KEYWORD0) + k);
         end
      end
      return kind;
   endfunction

endpackage

### src/lts_ifs.sv
`timescale 1ns / 1ps

interface lts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_input;

   modport source (output valid, output ch, output end_of_input, input ready);
   modport sink (input valid, input ch, input end_of_input, output ready);
endinterface

interface lts_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  token_kind;
   logic [15:0] token_start;
   logic [15:0] token_length;
   logic [15:0] line_number;
   logic [2:0]  error_code;
   logic        last;

   modport source (output valid, output token_kind, output token_start,
                   output token_length, output line_number, output error_code,
                   output last, input ready);
   modport sink (input valid, input token_kind, input token_start,
                 input token_length, input line_number, input error_code,
                 input last, output ready);
endinterface

### src/lts_result_queue.sv
`timescale 1ns / 1ps

module lts_result_queue (
   input  logic              clock,
   input  logic              reset,
   input  lts_pkg::push_type push,
   output logic              room,
   lts_rsp_if.source         rsp_chan
);
   import lts_pkg::*;

   token_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [QPTR_W-1:0] wr_next;
   logic [1:0]        n_push;
   logic              pop;
   token_type         head;

   assign pop     = rsp_chan.valid && rsp_chan.ready;
   assign n_push  = {1'b0, push.first_valid} + {1'b0, push.second_valid};
   assign wr_next = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(n_push);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(n_push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         slot_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         slot_ff[wr_next] <= push.second;
      end
   end

   assign head  = slot_ff[rd_ptr_ff];
   assign room  = count_ff <= QCNT_W'(QUEUE_DEPTH - 2);

   assign rsp_chan.valid        = count_ff != '0;
   assign rsp_chan.token_kind   = head.kind;
   assign rsp_chan.token_start  = head.start;
   assign rsp_chan.token_length = head.length;
   assign rsp_chan.line_number  = head.line;
   assign rsp_chan.error_code   = head.error;
   assign rsp_chan.last         = head.last;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue count beyond its depth");

   a_pair_fits: assert property (@(posedge clock) disable iff (reset)
      push.second_valid |-> push.first_valid && count_ff <= QCNT_W'(QUEUE_DEPTH - 2))
      else $error("two words pushed without room for both");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !push.first_valid) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count did not fall after a word was taken");

endmodule

### src/lexer_token_scanner.sv
`timescale 1ns / 1ps

// Lexical scanner that takes one source byte per word on the request channel
// and returns tokens on the response channel, each with its kind, start offset,
// length, line and error code; a request word with end_of_input set flushes any
// pending token and adds an end-of-file token, then the scanner starts afresh.
// A request word is taken every cycle while the four-word result queue has room
// for two tokens, so the sustained rate is one byte per cycle whenever the
// response side keeps up; a byte that closes one token and is itself a
// one-character token gives two words, marked by last on the second. The scan
// state is updated in the cycle a byte is taken, and a token is presented on
// the response channel from the cycle after if no words are queued ahead of it.

module lexer_token_scanner (
   input logic       clock,
   input logic       reset,
   lts_req_if.sink   req_chan,
   lts_rsp_if.source rsp_chan
);
   import lts_pkg::*;

   mode_type          mode_ff, mode_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  tb_ff, tb_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [WL_W-1:0]   wl_ff, wl_in;
   logic              ps_ff, ps_in;
   logic [2:0]        ne_ff, ne_in;
   word_buf_type      word_buf_ff;

   logic              wb_we;
   logic [WIDX_W-1:0] wb_idx;
   logic [7:0]        ch;
   logic              accept;
   logic              room;
   logic [POS_W-1:0]  pos_next;
   logic [5:0]        ident_kind;
   logic [5:0]        op_kind;

   logic              a_v, b_v;
   logic [5:0]        a_kind, b_kind;
   logic [POS_W-1:0]  a_end, b_end;
   logic [2:0]        a_err, b_err;
   logic              rescan, chk_exp, chk_suf;
   token_type         tok_a, tok_b;
   push_type          push;

   assign ch         = req_chan.ch;
   assign accept     = req_chan.valid && req_chan.ready;
   assign pos_next   = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
   assign ident_kind = kw_kind(word_buf_ff, wl_ff);
   assign req_chan.ready = room;

   always_comb begin
      case (mode_ff)
         M_BANG:    op_kind = K_BANG;
         M_EQ:      op_kind = K_EQUAL;
         M_LESS:    op_kind = K_LESS;
         M_GREATER: op_kind = K_GREATER;
         default:   op_kind = K_SLASH;
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      pos_in  = pos_ff;
      tb_in   = tb_ff;
      line_in = line_ff;
      wl_in   = wl_ff;
      ps_in   = ps_ff;
      ne_in   = ne_ff;
      wb_we   = 1'b0;
      wb_idx  = wl_ff[WIDX_W-1:0];
      a_v     = 1'b0;
      a_kind  = K_IDENT;
      a_end   = pos_ff;
      a_err   = ERR_NONE;
      b_v     = 1'b0;
      b_kind  = K_EOF;
      b_end   = pos_ff;
      b_err   = ERR_NONE;
      rescan  = 1'b0;
      chk_exp = 1'b0;
      chk_suf = 1'b0;

      if (req_chan.end_of_input) begin
         a_end = pos_ff;
         case (mode_ff)
            M_BANG, M_EQ, M_LESS, M_GREATER, M_SLASH: begin
               a_v    = 1'b1;
               a_kind = op_kind;
            end
            M_DOT: begin
               a_v    = 1'b1;
               a_kind = K_DOT;
            end
            M_IDENT: begin
               a_v    = 1'b1;
               a_kind = ident_kind;
            end
            M_NUM_POINT: begin
               a_v    = 1'b1;
               a_kind = K_NUMBER;
               a_err  = first_err(ne_ff, ERR_NO_FRACTION);
            end
            M_EXP_SIGN, M_EXP_FIRST: begin
               a_v    = 1'b1;
               a_kind = K_NUMBER;
               a_err  = first_err(ne_ff, ERR_NO_EXPONENT);
            end
            M_NUM_BODY, M_EXP_DIGITS, M_SUF_DIGITS: begin
               a_v    = 1'b1;
               a_kind = K_NUMBER;
               a_err  = ne_ff;
            end
            default: begin
               a_v = 1'b0;
            end
         endcase
         b_v     = 1'b1;
         b_kind  = K_EOF;
         b_end   = pos_ff;
         mode_in = M_IDLE;
         pos_in  = '0;
         tb_in   = '0;
         line_in = LINE_W'(1);
         wl_in   = '0;
         ps_in   = 1'b0;
         ne_in   = ERR_NONE;
      end else begin
         pos_in = pos_next;
         case (mode_ff)
            M_BANG, M_EQ, M_LESS, M_GREATER: begin
               a_v = 1'b1;
               if (ch == CH_EQUAL) begin
                  a_kind  = op_kind + 1'b1;
                  a_end   = pos_next;
                  mode_in = M_IDLE;
               end else begin
                  a_kind = op_kind;
                  rescan = 1'b1;
               end
            end
            M_SLASH: begin
               if (ch == CH_SLASH) begin
                  mode_in = M_COMMENT;
               end else begin
                  a_v    = 1'b1;
                  a_kind = K_SLASH;
                  rescan = 1'b1;
               end
            end
            M_COMMENT: begin
               rescan = (ch == CH_NEWLINE);
            end
            M_DOT: begin
               if (is_digit(ch)) begin
                  mode_in = M_NUM_BODY;
                  ps_in   = 1'b1;
                  ne_in   = ERR_NONE;
               end else begin
                  a_v    = 1'b1;
                  a_kind = K_DOT;
                  rescan = 1'b1;
               end
            end
            M_IDENT: begin
               if (is_alpha(ch) || is_digit(ch)) begin
                  wb_we = wl_ff < WL_W'(KW_MAX);
                  if (wl_ff <= WL_W'(KW_MAX)) begin
                     wl_in = wl_ff + 1'b1;
                  end
               end else begin
                  a_v    = 1'b1;
                  a_kind = ident_kind;
                  rescan = 1'b1;
               end
            end
            M_NUM_BODY: begin
               if (ch == CH_POINT) begin
                  if (ps_ff) begin
                     ne_in   = first_err(ne_ff, ERR_TWO_POINTS);
                     chk_exp = 1'b1;
                  end else begin
                     ps_in   = 1'b1;
                     mode_in = M_NUM_POINT;
                  end
               end else if (!is_digit(ch)) begin
                  chk_exp = 1'b1;
               end
            end
            M_NUM_POINT: begin
               if (is_digit(ch)) begin
                  mode_in = M_NUM_BODY;
               end else begin
                  ne_in   = first_err(ne_ff, ERR_NO_FRACTION);
                  chk_exp = 1'b1;
               end
            end
            M_EXP_SIGN: begin
               if (ch == CH_PLUS || ch == CH_MINUS) begin
                  mode_in = M_EXP_FIRST;
               end else if (is_digit(ch)) begin
                  mode_in = M_EXP_DIGITS;
               end else begin
                  ne_in   = first_err(ne_ff, ERR_NO_EXPONENT);
                  chk_suf = 1'b1;
               end
            end
            M_EXP_FIRST: begin
               if (is_digit(ch)) begin
                  mode_in = M_EXP_DIGITS;
               end else begin
                  ne_in   = first_err(ne_ff, ERR_NO_EXPONENT);
                  chk_suf = 1'b1;
               end
            end
            M_EXP_DIGITS: begin
               chk_suf = !is_digit(ch);
            end
            M_SUF_DIGITS: begin
               if (!is_digit(ch)) begin
                  a_v    = 1'b1;
                  a_kind = K_NUMBER;
                  a_err  = ne_ff;
                  rescan = 1'b1;
               end
            end
            default: begin
               rescan = 1'b1;
            end
         endcase

         if (chk_exp) begin
            if (ch == CH_LOWER_E || ch == CH_UPPER_E) begin
               mode_in = M_EXP_SIGN;
            end else begin
               chk_suf = 1'b1;
            end
         end

         if (chk_suf) begin
            if (ch == CH_LOWER_F) begin
               a_v     = 1'b1;
               a_kind  = K_NUMBER;
               a_end   = pos_next;
               a_err   = ne_in;
               mode_in = M_IDLE;
            end else if (ch == CH_LOWER_I || ch == CH_LOWER_U) begin
               mode_in = M_SUF_DIGITS;
            end else begin
               a_v    = 1'b1;
               a_kind = K_NUMBER;
               a_err  = ne_in;
               rescan = 1'b1;
            end
         end

         if (rescan) begin
            mode_in = M_IDLE;
            tb_in   = pos_ff;
            b_end   = pos_next;
            case (ch)
               CH_LPAREN: begin
                  b_v = 1'b1; b_kind = K_LPAREN;
               end
               CH_RPAREN: begin
                  b_v = 1'b1; b_kind = K_RPAREN;
               end
               CH_LBRACE: begin
                  b_v = 1'b1; b_kind = K_LBRACE;
               end
               CH_RBRACE: begin
                  b_v = 1'b1; b_kind = K_RBRACE;
               end
               CH_COMMA: begin
                  b_v = 1'b1; b_kind = K_COMMA;
               end
               CH_MINUS: begin
                  b_v = 1'b1; b_kind = K_MINUS;
               end
               CH_PLUS: begin
                  b_v = 1'b1; b_kind = K_PLUS;
               end
               CH_SEMI: begin
                  b_v = 1'b1; b_kind = K_SEMI;
               end
               CH_ASTERISK: begin
                  b_v = 1'b1; b_kind = K_ASTERISK;
               end
               CH_LBRACKET: begin
                  b_v = 1'b1; b_kind = K_LBRACKET;
               end
               CH_RBRACKET: begin
                  b_v = 1'b1; b_kind = K_RBRACKET;
               end
               CH_BANG:    mode_in = M_BANG;
               CH_EQUAL:   mode_in = M_EQ;
               CH_LESS:    mode_in = M_LESS;
               CH_GREATER: mode_in = M_GREATER;
               CH_SLASH:   mode_in = M_SLASH;
               CH_POINT:   mode_in = M_DOT;
               CH_SPACE, CH_CR, CH_TAB, CH_QUOTE: begin
                  mode_in = M_IDLE;
               end
               CH_NEWLINE: begin
                  if (line_ff != LINE_MAX) begin
                     line_in = line_ff + 1'b1;
                  end
               end
               default: begin
                  if (is_digit(ch)) begin
                     mode_in = M_NUM_BODY;
                     ps_in   = 1'b0;
                     ne_in   = ERR_NONE;
                  end else if (is_alpha(ch)) begin
                     mode_in = M_IDENT;
                     wb_we   = 1'b1;
                     wb_idx  = '0;
                     wl_in   = WL_W'(1);
                  end else begin
                     b_v    = 1'b1;
                     b_kind = K_ERROR;
                     b_err  = ERR_UNEXPECTED;
                  end
               end
            endcase
         end
      end
   end

   always_comb begin
      tok_a.kind   = a_kind;
      tok_a.start  = sat16(32'(tb_ff));
      tok_a.length = token_len(a_end, tb_ff);
      tok_a.line   = sat16(32'(line_ff));
      tok_a.error  = a_err;
      tok_a.last   = !b_v;

      tok_b.kind   = b_kind;
      tok_b.start  = sat16(32'(pos_ff));
      tok_b.length = token_len(b_end, pos_ff);
      tok_b.line   = sat16(32'(line_ff));
      tok_b.error  = b_err;
      tok_b.last   = 1'b1;

      push.first_valid  = accept && (a_v || b_v);
      push.second_valid = accept && a_v && b_v;
      push.first        = a_v ? tok_a : tok_b;
      push.second       = tok_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         pos_ff  <= '0;
         tb_ff   <= '0;
         line_ff <= LINE_W'(1);
         wl_ff   <= '0;
         ps_ff   <= 1'b0;
         ne_ff   <= ERR_NONE;
      end else if (accept) begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         tb_ff   <= tb_in;
         line_ff <= line_in;
         wl_ff   <= wl_in;
         ps_ff   <= ps_in;
         ne_ff   <= ne_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && wb_we) begin
         word_buf_ff[wb_idx] <= ch;
      end
   end

   lts_result_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

   a_eof_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.end_of_input)
      |=> mode_ff == M_IDLE && pos_ff == '0 && line_ff == LINE_W'(1))
      else $error("scanner state not cleared after end of input");

   a_begin_behind: assert property (@(posedge clock) disable iff (reset)
      tb_ff <= pos_ff)
      else $error("token start lies beyond the current position");

   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_chan.end_of_input && pos_ff != POS_MAX)
      |=> pos_ff == $past(pos_ff) + 1'b1)
      else $error("position did not advance by one byte");

endmodule
